// File: design/wsfu_pkg.sv
// ----------------------------------------------------------------------------
// wsfu_pkg
// Shared types and codes for the WebSocket frame unmasker.
// ----------------------------------------------------------------------------
package wsfu_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned KIND_W      = 3;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned MASK_BYTES  = 4;
    localparam int unsigned KEY_W       = MASK_BYTES * BYTE_W;

    // Opcode bytes and length codes of the frame header
    localparam logic [BYTE_W-1:0] OPC_BINARY_FINAL = 8'd130;
    localparam logic [BYTE_W-1:0] OPC_CLOSE_FINAL  = 8'd136;
    localparam logic [6:0]        LEN_CODE_EXT16   = 7'd126;
    localparam logic [6:0]        LEN_CODE_EXT64   = 7'd127;

    // Result kinds, carried on tuser
    localparam logic [KIND_W-1:0] KIND_DATA       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BAD_OPCODE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BAD_LENGTH = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NO_MASK    = 3'd5;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_result;

endpackage

// File: design/websocket_frame_unmasker.sv
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Parses masked client WebSocket frames and emits unmasked payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis takes one raw frame byte per transaction on tdata.
//   Master stream m_axis gives zero or one result per input byte: tdata is
//   the unmasked payload byte (zero for other kinds), tuser the result kind
//   (payload, empty frame, close notice, bad opcode, unsupported length,
//   missing mask), tlast marks the final payload byte of a frame.
//   Path: a byte taken from s_axis is held in the input register, goes
//   through the parser logic and shows its result on m_axis from the
//   result register.
//   Throughput: one byte per cycle unless m_axis stalls; the header state
//   update and the key XOR form one logic level between the two registers.
//   Header bytes that give no close notice, end no empty frame and do not
//   fail produce nothing. After a close notice or any error the parser drops
//   all further bytes until reset; s_axis keeps accepting them.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   parser to waiting for an opcode byte.
//   When the receiver stalls, the result register holds its transaction and
//   s_axis fills an empty input register with one more byte, then stops.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker
    import wsfu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] raw_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] payload_byte
    output logic [KIND_W-1:0] m_axis_tuser,   // [2:0] kind
    output logic              m_axis_tlast
);

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              out_free;
    logic              step;
    t_result           result;

    // advance the parser whenever a byte is held and the result slot is free
    assign step = in_valid && out_free;

    wsfu_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_consume (step),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    wsfu_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (in_byte),
        .o_result (result)
    );

    wsfu_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_kind   (m_axis_tuser),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

// File: design/wsfu_in_stage.sv
// ----------------------------------------------------------------------------
// wsfu_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module wsfu_in_stage
    import wsfu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_consume,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // refill in the same cycle the held byte is consumed
    assign o_ready = !r_valid || i_consume;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

// File: design/wsfu_parser.sv
// ----------------------------------------------------------------------------
// wsfu_parser
// Header state machine and payload unmasking, one byte per step.
// ----------------------------------------------------------------------------
module wsfu_parser
    import wsfu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_result
);

    localparam logic [2:0] PH_OPCODE  = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [2:0]       r_phase,   n_phase;
    logic [1:0]       r_hdr_cnt, n_hdr_cnt;
    logic [LEN_W-1:0] r_len,     n_len;
    logic [KEY_W-1:0] r_key,     n_key;
    logic [LEN_W-1:0] r_idx,     n_idx;
    logic             r_halted,  n_halted;

    logic [BYTE_W-1:0] key_byte;
    logic [LEN_W:0]    idx_plus1;
    logic              fin;

    always_comb begin
        case (r_idx[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    assign idx_plus1 = {1'b0, r_idx} + {{LEN_W{1'b0}}, 1'b1};
    assign fin       = idx_plus1 >= {1'b0, r_len};

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_len     = r_len;
        n_key     = r_key;
        n_idx     = r_idx;
        n_halted  = r_halted;
        o_result  = '0;

        if (i_step && !r_halted) begin
            case (r_phase)
                PH_LENGTH: begin
                    if (!i_byte[7]) begin
                        n_halted      = 1'b1;
                        o_result.valid = 1'b1;
                        o_result.kind  = KIND_NO_MASK;
                    end else if (i_byte[6:0] == LEN_CODE_EXT64) begin
                        n_halted      = 1'b1;
                        o_result.valid = 1'b1;
                        o_result.kind  = KIND_BAD_LENGTH;
                    end else begin
                        n_hdr_cnt = 2'd0;
                        if (i_byte[6:0] == LEN_CODE_EXT16) begin
                            n_len   = '0;
                            n_phase = PH_EXTLEN;
                        end else begin
                            n_len   = {{(LEN_W-7){1'b0}}, i_byte[6:0]};
                            n_phase = PH_KEY;
                        end
                    end
                end
                PH_EXTLEN: begin
                    n_len = {r_len[LEN_W-BYTE_W-1:0], i_byte};
                    if (r_hdr_cnt == 2'd1) begin
                        n_hdr_cnt = 2'd0;
                        n_phase   = PH_KEY;
                    end else begin
                        n_hdr_cnt = 2'd1;
                    end
                end
                PH_KEY: begin
                    n_key = {r_key[KEY_W-BYTE_W-1:0], i_byte};
                    if (r_hdr_cnt == 2'(MASK_BYTES - 1)) begin
                        n_hdr_cnt = 2'd0;
                        n_idx     = '0;
                        if (r_len == '0) begin
                            n_phase        = PH_OPCODE;
                            o_result.valid = 1'b1;
                            o_result.kind  = KIND_EMPTY;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        n_hdr_cnt = r_hdr_cnt + 2'd1;
                    end
                end
                PH_PAYLOAD: begin
                    o_result.valid = 1'b1;
                    o_result.kind  = KIND_DATA;
                    o_result.data  = i_byte ^ key_byte;
                    o_result.last  = fin;
                    if (fin) begin
                        n_idx   = '0;
                        n_phase = PH_OPCODE;
                    end else begin
                        n_idx = idx_plus1[LEN_W-1:0];
                    end
                end
                default: begin
                    if (i_byte == OPC_BINARY_FINAL) begin
                        n_phase   = PH_LENGTH;
                        n_hdr_cnt = 2'd0;
                    end else if (i_byte == OPC_CLOSE_FINAL) begin
                        n_halted       = 1'b1;
                        o_result.valid = 1'b1;
                        o_result.kind  = KIND_CLOSE;
                    end else begin
                        n_halted       = 1'b1;
                        o_result.valid = 1'b1;
                        o_result.kind  = KIND_BAD_OPCODE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OPCODE;
            r_hdr_cnt <= 2'd0;
            r_len     <= '0;
            r_key     <= '0;
            r_idx     <= '0;
            r_halted  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_len     <= n_len;
            r_key     <= n_key;
            r_idx     <= n_idx;
            r_halted  <= n_halted;
        end
    end

endmodule

// File: design/wsfu_out_stage.sv
// ----------------------------------------------------------------------------
// wsfu_out_stage
// Result register: holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module wsfu_out_stage
    import wsfu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_result           i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [KIND_W-1:0] o_kind,
    output logic [BYTE_W-1:0] o_data,
    output logic              o_last
);

    logic              r_valid;
    logic [KIND_W-1:0] r_kind;
    logic [BYTE_W-1:0] r_data;
    logic              r_last;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_data  = r_data;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_result.valid) begin
            r_kind <= i_result.kind;
            r_data <= i_result.data;
            r_last <= i_result.last;
        end
    end

endmodule

// File: design/wsfu_checker.sv
// ----------------------------------------------------------------------------
// wsfu_checker
// Port-level checks for the WebSocket frame unmasker.
// ----------------------------------------------------------------------------
module wsfu_checker
    import wsfu_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [BYTE_W-1:0] m_axis_tdata,
    input logic [KIND_W-1:0] m_axis_tuser,
    input logic              m_axis_tlast
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_last_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_DATA)
        else $error("tlast on a non-payload result");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata == '0)
        else $error("non-payload result carries data");

    // a terminal result is the final one until reset
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser != KIND_DATA
            && m_axis_tuser != KIND_EMPTY |=> !m_axis_tvalid)
        else $error("result after close notice or error");

endmodule

bind websocket_frame_unmasker wsfu_checker u_wsfu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
